// File: rtl/sia_pkg.sv
// sia_pkg: shared types and constants for the slot index allocator.
// Used by sia_ctrl, sia_datapath and slot_index_allocator; depends on nothing.

package sia_pkg;

    // Fixed field widths of the item and result ports
    localparam int IDX_W  = 12;
    localparam int HW_W   = 13;
    localparam int ACT_W  = 3;
    localparam int STAT_W = 3;
    localparam int CB_W   = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_BITS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUARANTINE = 1'b1;

    // Largest useful chunk size exponent; larger settings act as this
    localparam logic [CB_W-1:0] CHUNK_BITS_MAX   = 4'd12;
    localparam logic [CB_W-1:0] CHUNK_BITS_RESET = 4'd6;

    // Actions
    localparam logic [ACT_W-1:0] ACT_ALLOC    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_RELEASE  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_FREE_NOW = 3'd2;
    localparam logic [ACT_W-1:0] ACT_RESTORE  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_MARK     = 3'd4;
    localparam logic [ACT_W-1:0] ACT_FINALIZE = 3'd5;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK          = 3'd0;
    localparam logic [STAT_W-1:0] STAT_EXHAUSTED   = 3'd1;
    localparam logic [STAT_W-1:0] STAT_NO_MEMORY   = 3'd2;
    localparam logic [STAT_W-1:0] STAT_QUARANTINED = 3'd3;
    localparam logic [STAT_W-1:0] STAT_STACK_FULL  = 3'd4;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;      // input transfer, latch the item
        logic sweep_step;  // clear one mark entry and step the sweep counter
        logic sweep_push;  // sweep belongs to a finalize: push the holes
        logic commit;      // apply the item and load the result register
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic sweep_last;  // sweep counter sits on entry zero
    } ctrl_stat_t;

endpackage

// File: rtl/sia_ctrl.sv
// sia_ctrl: state machine sequencing the slot index allocator.
// Depends on sia_pkg for the command/status structs and action codes.

module sia_ctrl
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [sia_pkg::ACT_W-1:0]    action,
    output logic                         out_valid,
    input  logic                         out_ready,
    output sia_pkg::ctrl_cmd_t           cmd,
    input  sia_pkg::ctrl_stat_t          stat
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_SWEEP = 2'd2;
    localparam logic [1:0] S_EXEC  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    always_comb
    begin
        in_ready       = (state_reg == S_IDLE);
        out_free       = !out_valid_reg || out_ready;
        cmd.accept     = in_ready && in_valid;
        cmd.commit     = (state_reg == S_EXEC) && out_free;
        cmd.sweep_step = (state_reg == S_CLEAR) || (state_reg == S_SWEEP);
        cmd.sweep_push = (state_reg == S_SWEEP);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (stat.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd.accept)
                begin
                    state_next = (action == sia_pkg::ACT_FINALIZE) ? S_SWEEP : S_EXEC;
                end
            end
            S_SWEEP:
            begin
                if (stat.sweep_last)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd.commit)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> !in_ready)
        else $error("input taken again before the item finished");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid)
        else $error("committed result not presented");

    a_sweep_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP && stat.sweep_last) |=> (state_reg == S_EXEC))
        else $error("finalize sweep did not end in execute");
`endif

endmodule

// File: rtl/sia_datapath.sv
// sia_datapath: allocator state, free stack and mark memories, result register.
// Depends on sia_pkg; driven by sia_ctrl through ctrl_cmd_t.

module sia_datapath
#(
    parameter int SLOT_CAPACITY = 4096,
    parameter int CHUNK_LIMIT   = 64
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  sia_pkg::ctrl_cmd_t                cmd,
    output sia_pkg::ctrl_stat_t               stat,
    input  logic                              cfg_we,
    input  logic [sia_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sia_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [sia_pkg::ACT_W-1:0]         action,
    input  logic [sia_pkg::IDX_W-1:0]         slot_index,
    input  logic [sia_pkg::HW_W-1:0]          high_water_value,
    input  logic                              backing_granted,
    output logic [sia_pkg::STAT_W-1:0]        status,
    output logic [sia_pkg::IDX_W-1:0]         granted_index,
    output logic [sia_pkg::HW_W-1:0]          live_slots,
    output logic [sia_pkg::HW_W-1:0]          high_water_now,
    output logic [sia_pkg::HW_W-1:0]          capacity_slots
);

    localparam int CW = $clog2(SLOT_CAPACITY + 1);
    localparam int AW = $clog2(SLOT_CAPACITY);
    localparam int BW = $clog2(CHUNK_LIMIT + 1);

    localparam logic [CW-1:0] CAP       = CW'(SLOT_CAPACITY);
    localparam logic [AW-1:0] LAST_ADDR = AW'(SLOT_CAPACITY - 1);
    localparam logic [BW-1:0] MAXC      = BW'(CHUNK_LIMIT);

    // configuration
    logic [sia_pkg::CB_W-1:0]   chunk_bits_reg;
    logic                       quarantine_reg;

    // latched item
    logic [sia_pkg::ACT_W-1:0]  act_reg;
    logic [sia_pkg::IDX_W-1:0]  idx_reg;
    logic [sia_pkg::HW_W-1:0]   hwin_reg;
    logic                       granted_reg;

    // allocator state
    logic [CW-1:0] free_top_reg;
    logic [CW-1:0] free_top_next;
    logic [CW-1:0] high_water_reg;
    logic [CW-1:0] high_water_next;
    logic [BW-1:0] backed_reg;
    logic [BW-1:0] backed_next;
    logic [CW-1:0] live_reg;
    logic [CW-1:0] live_next;
    logic [CW-1:0] mark_count_reg;
    logic [CW-1:0] mark_count_next;

    // memories
    logic [sia_pkg::IDX_W-1:0] stack_mem [SLOT_CAPACITY];
    logic [sia_pkg::IDX_W-1:0] stack_rd_reg;
    logic                      mark_mem [SLOT_CAPACITY];
    logic                      mark_rd_reg;

    // mark sweep
    logic [AW-1:0] sweep_cnt_reg;
    logic          pend_valid_reg;
    logic [AW-1:0] pend_idx_reg;
    logic          pend_push;

    // result register
    logic [sia_pkg::STAT_W-1:0] status_reg;
    logic [sia_pkg::STAT_W-1:0] status_next;
    logic [sia_pkg::IDX_W-1:0]  grant_reg;
    logic [sia_pkg::IDX_W-1:0]  grant_next;
    logic [sia_pkg::HW_W-1:0]   live_out_reg;
    logic [sia_pkg::HW_W-1:0]   hw_out_reg;
    logic [sia_pkg::HW_W-1:0]   cap_out_reg;

    logic [sia_pkg::CB_W-1:0] bits;
    logic [31:0]              hw_chunk;
    logic [31:0]              needed;
    logic [31:0]              cap_wide;
    logic [31:0]              cap_sat;
    logic                     push_req;
    logic                     mark_we_item;

    assign bits     = (chunk_bits_reg > sia_pkg::CHUNK_BITS_MAX) ?
                      sia_pkg::CHUNK_BITS_MAX : chunk_bits_reg;
    assign hw_chunk = 32'(high_water_reg) >> bits;
    assign needed   = ((32'(hwin_reg) - 32'd1) >> bits) + 32'd1;

    always_comb
    begin
        free_top_next   = free_top_reg;
        high_water_next = high_water_reg;
        backed_next     = backed_reg;
        live_next       = live_reg;
        mark_count_next = mark_count_reg;
        status_next     = sia_pkg::STAT_OK;
        grant_next      = '0;
        push_req        = 1'b0;
        mark_we_item    = 1'b0;

        unique case (act_reg)
            sia_pkg::ACT_ALLOC:
            begin
                if (free_top_reg != '0)
                begin
                    free_top_next = free_top_reg - CW'(1);
                    grant_next    = stack_rd_reg;
                    if (live_reg < CAP)
                    begin
                        live_next = live_reg + CW'(1);
                    end
                end
                else if (high_water_reg >= CAP)
                begin
                    status_next = sia_pkg::STAT_EXHAUSTED;
                end
                else
                begin
                    if (hw_chunk >= 32'(backed_reg))
                    begin
                        if (hw_chunk >= 32'(CHUNK_LIMIT))
                        begin
                            status_next = sia_pkg::STAT_EXHAUSTED;
                        end
                        else if (!granted_reg)
                        begin
                            status_next = sia_pkg::STAT_NO_MEMORY;
                        end
                        else
                        begin
                            backed_next = BW'(hw_chunk + 32'd1);
                        end
                    end
                    if (status_next == sia_pkg::STAT_OK)
                    begin
                        grant_next      = sia_pkg::IDX_W'(high_water_reg);
                        high_water_next = high_water_reg + CW'(1);
                        if (live_reg < CAP)
                        begin
                            live_next = live_reg + CW'(1);
                        end
                    end
                end
            end
            sia_pkg::ACT_RELEASE, sia_pkg::ACT_FREE_NOW:
            begin
                if (act_reg == sia_pkg::ACT_RELEASE && live_reg != '0)
                begin
                    live_next = live_reg - CW'(1);
                end
                if (act_reg == sia_pkg::ACT_RELEASE && quarantine_reg)
                begin
                    status_next = sia_pkg::STAT_QUARANTINED;
                end
                else if (free_top_reg >= CAP)
                begin
                    status_next = sia_pkg::STAT_STACK_FULL;
                end
                else
                begin
                    push_req      = 1'b1;
                    free_top_next = free_top_reg + CW'(1);
                end
            end
            sia_pkg::ACT_RESTORE:
            begin
                if (hwin_reg == '0)
                begin
                    high_water_next = '0;
                end
                else if (32'(hwin_reg) > 32'(SLOT_CAPACITY))
                begin
                    status_next = sia_pkg::STAT_EXHAUSTED;
                end
                else
                begin
                    // chunks are backed contiguously, so only the first unbacked one decides
                    if (needed > 32'(backed_reg))
                    begin
                        if (backed_reg >= MAXC)
                        begin
                            status_next = sia_pkg::STAT_EXHAUSTED;
                        end
                        else if (!granted_reg)
                        begin
                            status_next = sia_pkg::STAT_NO_MEMORY;
                        end
                        else if (needed > 32'(CHUNK_LIMIT))
                        begin
                            backed_next = MAXC;
                            status_next = sia_pkg::STAT_EXHAUSTED;
                        end
                        else
                        begin
                            backed_next = BW'(needed);
                        end
                    end
                    if (status_next == sia_pkg::STAT_OK)
                    begin
                        high_water_next = CW'(hwin_reg);
                        live_next       = '0;
                    end
                end
            end
            sia_pkg::ACT_MARK:
            begin
                mark_we_item = (32'(idx_reg) < 32'(SLOT_CAPACITY));
                if (mark_count_reg < CAP)
                begin
                    mark_count_next = mark_count_reg + CW'(1);
                end
            end
            sia_pkg::ACT_FINALIZE:
            begin
                live_next       = mark_count_reg;
                mark_count_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    assign cap_wide = 32'(backed_next) << bits;
    assign cap_sat  = (cap_wide > 32'(SLOT_CAPACITY)) ? 32'(SLOT_CAPACITY) : cap_wide;

    // a hole found by the sweep: below high water and not marked live
    assign pend_push = pend_valid_reg && !mark_rd_reg &&
                       (32'(pend_idx_reg) < 32'(high_water_reg));

    assign stat.sweep_last = (sweep_cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_bits_reg <= sia_pkg::CHUNK_BITS_RESET;
            quarantine_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sia_pkg::CFG_CHUNK_BITS: chunk_bits_reg <= cfg_data;
                sia_pkg::CFG_QUARANTINE: quarantine_reg <= cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            act_reg     <= action;
            idx_reg     <= slot_index;
            hwin_reg    <= high_water_value;
            granted_reg <= backing_granted;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_top_reg   <= '0;
            high_water_reg <= '0;
            backed_reg     <= '0;
            live_reg       <= '0;
            mark_count_reg <= '0;
        end
        else
        begin
            priority if (cmd.accept && action == sia_pkg::ACT_FINALIZE)
            begin
                free_top_reg <= '0;
            end
            else if (pend_push)
            begin
                free_top_reg <= free_top_reg + CW'(1);
            end
            else if (cmd.commit)
            begin
                free_top_reg <= free_top_next;
            end
            if (cmd.commit)
            begin
                high_water_reg <= high_water_next;
                backed_reg     <= backed_next;
                live_reg       <= live_next;
                mark_count_reg <= mark_count_next;
            end
        end
    end

    // free stack: one write, one registered read at the current top
    always_ff @(posedge clk)
    begin
        if (pend_push)
        begin
            stack_mem[AW'(free_top_reg)] <= sia_pkg::IDX_W'(pend_idx_reg);
        end
        else if (cmd.commit && push_req)
        begin
            stack_mem[AW'(free_top_reg)] <= idx_reg;
        end
        stack_rd_reg <= stack_mem[AW'(free_top_reg - CW'(1))];
    end

    // live marks: the sweep reads and clears the same entry in the same cycle
    always_ff @(posedge clk)
    begin
        if (cmd.sweep_step)
        begin
            mark_mem[sweep_cnt_reg] <= 1'b0;
        end
        else if (cmd.commit && mark_we_item)
        begin
            mark_mem[AW'(idx_reg)] <= 1'b1;
        end
        mark_rd_reg <= mark_mem[sweep_cnt_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_cnt_reg  <= LAST_ADDR;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.sweep_step)
            begin
                sweep_cnt_reg <= (sweep_cnt_reg == '0) ? LAST_ADDR : sweep_cnt_reg - AW'(1);
            end
            pend_valid_reg <= cmd.sweep_step && cmd.sweep_push;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= sweep_cnt_reg;
        if (cmd.commit)
        begin
            status_reg   <= status_next;
            grant_reg    <= grant_next;
            live_out_reg <= sia_pkg::HW_W'(live_next);
            hw_out_reg   <= sia_pkg::HW_W'(high_water_next);
            cap_out_reg  <= sia_pkg::HW_W'(cap_sat);
        end
    end

    assign status         = status_reg;
    assign granted_index  = grant_reg;
    assign live_slots     = live_out_reg;
    assign high_water_now = hw_out_reg;
    assign capacity_slots = cap_out_reg;

`ifndef SYNTHESIS
    a_backed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (backed_reg <= MAXC))
        else $error("backed chunk count beyond the chunk limit");

    a_alloc_live: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && act_reg == sia_pkg::ACT_ALLOC && status_next == sia_pkg::STAT_OK)
        |=> (live_reg != '0))
        else $error("successful allocate left no live slot");

    a_sweep_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        pend_push |-> (free_top_reg < CAP))
        else $error("finalize push beyond the free stack");
`endif

endmodule

// File: rtl/slot_index_allocator.sv
// slot_index_allocator: top level of the LIFO slot allocator.
// Instantiates sia_ctrl and sia_datapath; uses sia_pkg for widths and codes.

// Hands out slot indices from a LIFO free stack, falling back to a high-water
// mark that backs new chunks of 2^n slots on demand, n set by register 0. One
// result per item. Allocate, release, early free, restore, mark_live and unused
// actions pass through input transfer, then execute into the result register
// (execute holds while an unaccepted result still occupies it); the free stack
// is a single memory read at its top, registered before use.
// Finalize sweeps the whole live-mark memory, one entry a cycle, rebuilding the
// free stack as it goes. After reset the mark memory is cleared by the same
// sweep with in_ready low; configuration writes are taken during that pass.
// A finished result may wait in the result register while the next item is
// transferred in.

module slot_index_allocator
#(
    parameter int SLOT_CAPACITY = 4096,
    parameter int CHUNK_LIMIT   = 64
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [sia_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sia_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [sia_pkg::ACT_W-1:0]         action,
    input  logic [sia_pkg::IDX_W-1:0]         slot_index,
    input  logic [sia_pkg::HW_W-1:0]          high_water_value,
    input  logic                              backing_granted,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [sia_pkg::STAT_W-1:0]        status,
    output logic [sia_pkg::IDX_W-1:0]         granted_index,
    output logic [sia_pkg::HW_W-1:0]          live_slots,
    output logic [sia_pkg::HW_W-1:0]          high_water_now,
    output logic [sia_pkg::HW_W-1:0]          capacity_slots
);

    sia_pkg::ctrl_cmd_t  cmd;
    sia_pkg::ctrl_stat_t stat;

    sia_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    sia_datapath
    #(
        .SLOT_CAPACITY (SLOT_CAPACITY),
        .CHUNK_LIMIT   (CHUNK_LIMIT)
    )
    u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .action           (action),
        .slot_index       (slot_index),
        .high_water_value (high_water_value),
        .backing_granted  (backing_granted),
        .status           (status),
        .granted_index    (granted_index),
        .live_slots       (live_slots),
        .high_water_now   (high_water_now),
        .capacity_slots   (capacity_slots)
    );

endmodule

// File: test/tb_top.sv
// tb_top: self-checking testbench for slot_index_allocator.
// Needs rtl/sia_pkg.sv and the slot_index_allocator RTL; reads no files.
// A directed table runs first, then randomised phases over several register settings.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOT_CAPACITY = 4096;
    localparam int CHUNK_LIMIT   = 64;

    localparam logic [sia_pkg::ACT_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [sia_pkg::ACT_W-1:0] ACT_SPARE_7 = 3'd7;

    localparam int N_PHASES     = 8;
    localparam int PHASE_ITEMS  = 175;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 50;
    // finalize sweep plus the longest receiver hold, with margin
    localparam int IDLE_LIMIT   = 20000;
    localparam int PRINT_LIMIT  = 40;

    typedef struct packed {
        logic [sia_pkg::ACT_W-1:0] act;
        logic [sia_pkg::IDX_W-1:0] idx;
        logic [sia_pkg::HW_W-1:0]  hw;
        logic                      grant;
    } slot_op_t;

    typedef struct packed {
        logic [sia_pkg::STAT_W-1:0] status;
        logic [sia_pkg::IDX_W-1:0]  index;
        logic [sia_pkg::HW_W-1:0]   live;
        logic [sia_pkg::HW_W-1:0]   hw_level;
        logic [sia_pkg::HW_W-1:0]   capacity;
    } outcome_t;

    typedef enum logic [0:0] {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t                      kind;
        slot_op_t                       op;
        logic                           fixed;
        outcome_t                       want;
        logic [sia_pkg::CFG_IDX_W-1:0]  reg_sel;
        logic [sia_pkg::CFG_DATA_W-1:0] reg_val;
    } test_step_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [sia_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [sia_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           in_valid;
    logic                           in_ready;
    logic [sia_pkg::ACT_W-1:0]      action;
    logic [sia_pkg::IDX_W-1:0]      slot_index;
    logic [sia_pkg::HW_W-1:0]       high_water_value;
    logic                           backing_granted;
    logic                           out_valid;
    logic                           out_ready;
    logic [sia_pkg::STAT_W-1:0]     status;
    logic [sia_pkg::IDX_W-1:0]      granted_index;
    logic [sia_pkg::HW_W-1:0]       live_slots;
    logic [sia_pkg::HW_W-1:0]       high_water_now;
    logic [sia_pkg::HW_W-1:0]       capacity_slots;

    // Allocator state as this bench sees it
    logic [sia_pkg::IDX_W-1:0] free_stack [SLOT_CAPACITY];
    int unsigned               fs_top;
    int unsigned               hw_mark;
    int unsigned               chunks_backed;
    int unsigned               live_cnt;
    bit [SLOT_CAPACITY-1:0]    marks;
    int unsigned               mark_cnt;
    int unsigned               chunk_bits_q;
    bit                        quarantine_q;

    outcome_t                  outcome_q [$];
    test_step_t                steps [$];
    logic [sia_pkg::IDX_W-1:0] issued_q [$];
    logic [sia_pkg::IDX_W-1:0] held_q [$];

    int unsigned n_errors;
    int unsigned items_sent;
    int unsigned quiet_cycles;
    bit          tx_calm;
    bit          rx_calm;
    bit          long_hold;

    int unsigned phase_bits [N_PHASES]    = '{6, 0, 12, 15, 3, 1, 9, 13};
    bit          phase_quar [N_PHASES]    = '{0, 1, 0, 1, 1, 0, 1, 0};
    bit          phase_tx_calm [N_PHASES] = '{1, 1, 0, 0, 1, 0, 0, 0};
    bit          phase_rx_calm [N_PHASES] = '{1, 0, 0, 1, 0, 0, 0, 0};

    slot_index_allocator #(
        .SLOT_CAPACITY (SLOT_CAPACITY),
        .CHUNK_LIMIT   (CHUNK_LIMIT)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .action           (action),
        .slot_index       (slot_index),
        .high_water_value (high_water_value),
        .backing_granted  (backing_granted),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .granted_index    (granted_index),
        .live_slots       (live_slots),
        .high_water_now   (high_water_now),
        .capacity_slots   (capacity_slots)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (n_errors < PRINT_LIMIT)
            $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        n_errors++;
    endtask

    function automatic int unsigned gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 60) : $urandom_range(1, 3);
    endfunction

    // Backs chunk number chunk unless already backed, beyond the chunk limit or not granted
    function automatic logic [sia_pkg::STAT_W-1:0] claim_chunk(input int unsigned chunk,
                                                               input logic grant);
        if (chunk < chunks_backed)
            return sia_pkg::STAT_OK;
        if (chunk >= CHUNK_LIMIT)
            return sia_pkg::STAT_EXHAUSTED;
        if (!grant)
            return sia_pkg::STAT_NO_MEMORY;
        chunks_backed = chunk + 1;
        return sia_pkg::STAT_OK;
    endfunction

    function automatic logic [sia_pkg::STAT_W-1:0] stack_push(
        input logic [sia_pkg::IDX_W-1:0] ix);
        if (fs_top >= SLOT_CAPACITY)
            return sia_pkg::STAT_STACK_FULL;
        free_stack[fs_top] = ix;
        fs_top++;
        return sia_pkg::STAT_OK;
    endfunction

    // Applies one operation to the local state and returns the outcome it gives
    function automatic outcome_t apply_slot_op(input slot_op_t op);
        outcome_t    r;
        int unsigned sh;
        int unsigned need;
        int unsigned c;
        int unsigned i;
        int unsigned cap;
        r = '0;
        sh = (chunk_bits_q > 32'(sia_pkg::CHUNK_BITS_MAX)) ?
             32'(sia_pkg::CHUNK_BITS_MAX) : chunk_bits_q;
        case (op.act)
            sia_pkg::ACT_ALLOC:
            begin
                if (fs_top > 0) begin
                    fs_top--;
                    r.index = free_stack[fs_top];
                    if (live_cnt < SLOT_CAPACITY)
                        live_cnt++;
                end
                else if (hw_mark >= SLOT_CAPACITY)
                    r.status = sia_pkg::STAT_EXHAUSTED;
                else
                begin
                    r.status = claim_chunk(hw_mark >> sh, op.grant);
                    if (r.status == sia_pkg::STAT_OK)
                    begin
                        r.index = sia_pkg::IDX_W'(hw_mark);
                        hw_mark++;
                        if (live_cnt < SLOT_CAPACITY)
                            live_cnt++;
                    end
                end
            end
            sia_pkg::ACT_RELEASE:
            begin
                if (live_cnt > 0)
                    live_cnt--;
                r.status = quarantine_q ? sia_pkg::STAT_QUARANTINED : stack_push(op.idx);
            end
            sia_pkg::ACT_FREE_NOW:
                r.status = stack_push(op.idx);
            sia_pkg::ACT_RESTORE:
            begin
                if (op.hw == 0)
                    hw_mark = 0;
                else if (op.hw > SLOT_CAPACITY)
                    r.status = sia_pkg::STAT_EXHAUSTED;
                else
                begin
                    need = ((32'(op.hw) - 1) >> sh) + 1;
                    for (c = 0; c < need && r.status == sia_pkg::STAT_OK; c++)
                        r.status = claim_chunk(c, op.grant);
                    if (r.status == sia_pkg::STAT_OK)
                    begin
                        hw_mark = 32'(op.hw);
                        live_cnt = 0;
                    end
                end
            end
            sia_pkg::ACT_MARK:
            begin
                marks[op.idx] = 1'b1;
                if (mark_cnt < SLOT_CAPACITY)
                    mark_cnt++;
            end
            sia_pkg::ACT_FINALIZE:
            begin
                // highest hole goes in first, so the lowest is handed out first
                fs_top = 0;
                for (i = hw_mark; i > 0; i--)
                    if (!marks[i-1] && fs_top < SLOT_CAPACITY)
                    begin
                        free_stack[fs_top] = sia_pkg::IDX_W'(i - 1);
                        fs_top++;
                    end
                live_cnt = mark_cnt;
                marks = '0;
                mark_cnt = 0;
            end
            default:
                ;
        endcase
        cap = chunks_backed << sh;
        r.live = sia_pkg::HW_W'(live_cnt);
        r.hw_level = sia_pkg::HW_W'(hw_mark);
        r.capacity = sia_pkg::HW_W'((cap > SLOT_CAPACITY) ? SLOT_CAPACITY : cap);
        return r;
    endfunction

    function automatic slot_op_t noise_op();
        slot_op_t op;
        op.act = sia_pkg::ACT_W'($urandom);
        op.idx = sia_pkg::IDX_W'($urandom);
        op.hw = sia_pkg::HW_W'($urandom);
        op.grant = ($urandom_range(0, 9) != 0);
        return op;
    endfunction

    function automatic void step_op(input logic [sia_pkg::ACT_W-1:0] act,
                                    input int unsigned ix,
                                    input int unsigned hw, input bit g);
        test_step_t s;
        s = '0;
        s.kind = ROW_ITEM;
        s.op = '{act: act, idx: sia_pkg::IDX_W'(ix), hw: sia_pkg::HW_W'(hw), grant: g};
        steps = {steps, s};
    endfunction

    function automatic void step_fixed(input logic [sia_pkg::ACT_W-1:0] act,
                                       input int unsigned hw,
                                       input bit g, input logic [sia_pkg::STAT_W-1:0] st,
                                       input int unsigned live, input int unsigned hwm,
                                       input int unsigned cap);
        test_step_t s;
        s = '0;
        s.kind = ROW_ITEM;
        s.op = '{act: act, idx: '0, hw: sia_pkg::HW_W'(hw), grant: g};
        s.fixed = 1'b1;
        s.want = '{status: st, index: '0, live: sia_pkg::HW_W'(live),
                   hw_level: sia_pkg::HW_W'(hwm), capacity: sia_pkg::HW_W'(cap)};
        steps = {steps, s};
    endfunction

    function automatic void step_cfg(input logic [sia_pkg::CFG_IDX_W-1:0] sel,
                                     input logic [sia_pkg::CFG_DATA_W-1:0] val);
        test_step_t s;
        s = '0;
        s.kind = ROW_CFG;
        s.reg_sel = sel;
        s.reg_val = val;
        steps = {steps, s};
    endfunction

    // Offers one operation and waits for its transfer; in_valid stays high afterwards
    task automatic put_item(input slot_op_t op, input logic fixed, input outcome_t want,
                            output outcome_t got);
        in_valid <= 1'b1;
        action <= op.act;
        slot_index <= op.idx;
        high_water_value <= op.hw;
        backing_granted <= op.grant;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        got = apply_slot_op(op);
        outcome_q = {outcome_q, (fixed ? want : got)};
        if (op.act == sia_pkg::ACT_ALLOC && got.status == sia_pkg::STAT_OK)
            issued_q = {issued_q, got.index};
        if (op.act == sia_pkg::ACT_RELEASE && got.status == sia_pkg::STAT_QUARANTINED)
            held_q = {held_q, op.idx};
        if (op.act != ACT_SPARE_6 && op.act != ACT_SPARE_7)
            items_sent++;
    endtask

    task automatic tx_gap();
        if (!tx_calm && $urandom_range(0, 2) == 0)
        begin
            in_valid <= 1'b0;
            repeat (gap_len()) @(posedge clk);
        end
    endtask

    // Steps the clock before the check, so in_valid is never driven twice in a step
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outcome_q.size() != 0);
    endtask

    task automatic write_reg(input logic [sia_pkg::CFG_IDX_W-1:0] sel,
                             input logic [sia_pkg::CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= sel;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (sel == sia_pkg::CFG_CHUNK_BITS)
            chunk_bits_q = 32'(val);
        else
            quarantine_q = val[0];
    endtask

    task automatic run_random(input int unsigned n_items);
        int unsigned               target;
        int unsigned               pick;
        int unsigned               pos;
        slot_op_t                  op;
        outcome_t                  got;
        logic [sia_pkg::IDX_W-1:0] marked [$];
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            pick = $urandom_range(0, 99);
            op = noise_op();
            if (pick < 3)
            begin
                // restore, a few marks, then finalize: the usual recovery flow
                op.act = sia_pkg::ACT_RESTORE;
                op.hw = ($urandom_range(0, 7) == 0) ? sia_pkg::HW_W'(SLOT_CAPACITY)
                                                    : sia_pkg::HW_W'($urandom_range(1, 300));
                op.grant = 1'b1;
                put_item(op, 1'b0, '0, got);
                tx_gap();
                marked.delete();
                repeat ($urandom_range(0, 12))
                begin
                    op = noise_op();
                    op.act = sia_pkg::ACT_MARK;
                    if (hw_mark > 0 && $urandom_range(0, 5) != 0)
                        op.idx = sia_pkg::IDX_W'($urandom_range(0, hw_mark - 1));
                    marked = {marked, op.idx};
                    put_item(op, 1'b0, '0, got);
                    tx_gap();
                end
                op = noise_op();
                op.act = sia_pkg::ACT_FINALIZE;
                put_item(op, 1'b0, '0, got);
                issued_q = marked;
            end
            else
            begin
                if (pick < 38 || pick >= 92)
                    op.act = sia_pkg::ACT_ALLOC;
                else if (pick < 63)
                begin
                    op.act = sia_pkg::ACT_RELEASE;
                    if (issued_q.size() > 0 && $urandom_range(0, 4) != 0)
                    begin
                        pos = $urandom_range(0, issued_q.size() - 1);
                        op.idx = issued_q[pos];
                        issued_q.delete(pos);
                    end
                end
                else if (pick < 71)
                begin
                    op.act = sia_pkg::ACT_FREE_NOW;
                    if (held_q.size() > 0 && $urandom_range(0, 4) != 0)
                    begin
                        pos = $urandom_range(0, held_q.size() - 1);
                        op.idx = held_q[pos];
                        held_q.delete(pos);
                    end
                end
                else if (pick < 77)
                begin
                    op.act = sia_pkg::ACT_RESTORE;
                    case ($urandom_range(0, 9))
                        0: op.hw = '0;
                        1: ;
                        2: op.hw = sia_pkg::HW_W'(SLOT_CAPACITY);
                        default: op.hw = sia_pkg::HW_W'($urandom_range(1, 600));
                    endcase
                end
                else if (pick < 87)
                begin
                    op.act = sia_pkg::ACT_MARK;
                    if (hw_mark > 0 && $urandom_range(0, 3) != 0)
                        op.idx = sia_pkg::IDX_W'($urandom_range(0, hw_mark - 1));
                end
                else if (pick < 89)
                    op.act = sia_pkg::ACT_FINALIZE;
                else
                    op.act = $urandom_range(0, 1) ? ACT_SPARE_6 : ACT_SPARE_7;
                put_item(op, 1'b0, '0, got);
            end
            tx_gap();
        end
    endtask

    // Receiver: random stalls, calm stretches, and one long hold on request
    initial
    begin : rx_side
        int unsigned hold_left;
        hold_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (long_hold)
            begin
                long_hold = 1'b0;
                hold_left = LONG_HOLD;
                out_ready <= 1'b0;
            end
            else if (rx_calm || $urandom_range(0, 3) != 0)
                out_ready <= 1'b1;
            else
            begin
                hold_left = gap_len() - 1;
                out_ready <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        outcome_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (outcome_q.size() == 0)
                report_mismatch("result with nothing pending, status", status, -1);
            else
            begin
                want = outcome_q.pop_front();
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
                if (granted_index !== want.index)
                    report_mismatch("granted_index", granted_index, want.index);
                if (live_slots !== want.live)
                    report_mismatch("live_slots", live_slots, want.live);
                if (high_water_now !== want.hw_level)
                    report_mismatch("high_water_now", high_water_now, want.hw_level);
                if (capacity_slots !== want.capacity)
                    report_mismatch("capacity_slots", capacity_slots, want.capacity);
            end
        end
    end

    // Watchdog: cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        outcome_t    got;
        int unsigned p;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        action <= '0;
        slot_index <= '0;
        high_water_value <= '0;
        backing_granted <= 1'b0;
        n_errors = 0;
        items_sent = 0;
        quiet_cycles = 0;
        fs_top = 0;
        hw_mark = 0;
        chunks_backed = 0;
        live_cnt = 0;
        marks = '0;
        mark_cnt = 0;
        chunk_bits_q = 32'(sia_pkg::CHUNK_BITS_RESET);
        quarantine_q = 1'b0;
        foreach (free_stack[k])
            free_stack[k] = '0;

        // Reset state: refused backing, spare action, restore far out of range
        step_fixed(sia_pkg::ACT_ALLOC, 0, 0, sia_pkg::STAT_NO_MEMORY, 0, 0, 0);
        step_fixed(ACT_SPARE_7, 0, 0, sia_pkg::STAT_OK, 0, 0, 0);
        step_fixed(sia_pkg::ACT_RESTORE, 8191, 1, sia_pkg::STAT_EXHAUSTED, 0, 0, 0);
        step_fixed(sia_pkg::ACT_ALLOC, 0, 1, sia_pkg::STAT_OK, 1, 1, 64);
        step_op(sia_pkg::ACT_ALLOC, 0, 0, 1);            // chunk already backed
        step_op(sia_pkg::ACT_RELEASE, 0, 0, 0);
        step_op(sia_pkg::ACT_ALLOC, 0, 0, 0);            // pops the freed index
        step_op(sia_pkg::ACT_FREE_NOW, 4095, 0, 0);
        step_op(sia_pkg::ACT_RESTORE, 0, 4096, 0);       // second chunk refused
        step_op(sia_pkg::ACT_RESTORE, 0, 4096, 1);
        step_op(sia_pkg::ACT_ALLOC, 0, 0, 1);
        step_op(sia_pkg::ACT_ALLOC, 0, 0, 1);            // index space full
        step_op(sia_pkg::ACT_MARK, 0, 0, 0);
        step_op(sia_pkg::ACT_MARK, 4095, 0, 0);
        step_op(sia_pkg::ACT_MARK, 4095, 0, 0);          // duplicate mark still counted
        step_op(sia_pkg::ACT_FINALIZE, 0, 0, 0);
        step_op(sia_pkg::ACT_ALLOC, 0, 0, 0);            // lowest hole first
        step_op(sia_pkg::ACT_FINALIZE, 0, 0, 0);         // no marks: stack fills completely
        step_op(sia_pkg::ACT_RELEASE, 5, 0, 0);          // push onto a full stack
        step_cfg(sia_pkg::CFG_QUARANTINE, 4'd1);
        step_op(sia_pkg::ACT_RELEASE, 9, 0, 0);
        step_op(sia_pkg::ACT_ALLOC, 0, 0, 0);
        step_op(sia_pkg::ACT_FREE_NOW, 9, 0, 0);
        step_op(sia_pkg::ACT_RESTORE, 0, 0, 0);
        step_op(sia_pkg::ACT_FINALIZE, 0, 0, 0);         // high water zero: empty stack
        step_cfg(sia_pkg::CFG_CHUNK_BITS, 4'd0);
        step_op(sia_pkg::ACT_RESTORE, 0, 70, 1);         // runs into the chunk limit
        step_op(sia_pkg::ACT_RESTORE, 0, 64, 1);
        step_op(sia_pkg::ACT_ALLOC, 0, 0, 1);            // chunk limit on allocate
        step_cfg(sia_pkg::CFG_CHUNK_BITS, 4'd15);
        step_op(ACT_SPARE_6, 0, 0, 0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (steps[n])
        begin
            if (steps[n].kind == ROW_CFG)
            begin
                wait_drained();
                write_reg(steps[n].reg_sel, steps[n].reg_val);
            end
            else
            begin
                put_item(steps[n].op, steps[n].fixed, steps[n].want, got);
                tx_gap();
            end
        end

        for (p = 0; p < N_PHASES; p++)
        begin
            wait_drained();
            write_reg(sia_pkg::CFG_CHUNK_BITS, sia_pkg::CFG_DATA_W'(phase_bits[p]));
            write_reg(sia_pkg::CFG_QUARANTINE, {3'($urandom_range(0, 7)), phase_quar[p]});
            tx_calm = phase_tx_calm[p];
            rx_calm = phase_rx_calm[p];
            // sender keeps offering while the receiver holds off
            if (p == 1 || p == 5)
                long_hold = 1'b1;
            run_random(PHASE_ITEMS);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/sia_pkg.sv
rtl/sia_ctrl.sv
rtl/sia_datapath.sv
rtl/slot_index_allocator.sv
test/tb_top.sv
